FILE: hdl/gclp_pkg.sv
// ----------------------------------------------------------------------------
// Gray coordinate line parser package
// Shared constants, codes, types and the hex digit decoder of the parser.
// ----------------------------------------------------------------------------
package gclp_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int SENSORS_DEF    = 4;
  localparam int COORD_BITS_DEF = 16;

  // Fixed widths of the ports.
  localparam int BYTE_W       = 8;
  localparam int COORD_OUT_W  = 16;
  localparam int SENSOR_IDX_W = 2;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // Character codes of the line format.
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_COLON   = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_COMMA   = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;

  // Reset values of the axis letter registers.
  localparam logic [BYTE_W-1:0] X_LETTER_RST = 8'd88;
  localparam logic [BYTE_W-1:0] Y_LETTER_RST = 8'd89;

  // Where the parser stands within the current line.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_AXIS   = 2'd1,
    PH_FIELDS = 2'd2,
    PH_DONE   = 2'd3
  } line_phase_e;

  // Axis chosen by the first byte of the line.
  typedef enum logic [1:0] {
    AX_NONE = 2'd0,
    AX_X    = 2'd1,
    AX_Y    = 2'd2
  } line_axis_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_X_LETTER = 1'b0,
    REG_Y_LETTER = 1'b1
  } cfg_reg_e;

  // Control handed from the parser to the result emitter at a newline.
  typedef struct packed {
    logic load;
    logic axis_is_y;
  } snap_ctrl_t;

  // One decoded character: whether it is a hex digit, and its value.
  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  // Decode one byte as a hex digit of either case.
  function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_digit_t r;
    r.is_hex = 1'b1;
    case (c) inside
      [8'h30:8'h39]: r.value = 4'(c - 8'h30);
      [8'h61:8'h66]: r.value = 4'(c - 8'h57);
      [8'h41:8'h46]: r.value = 4'(c - 8'h37);
      default: begin
        r.is_hex = 1'b0;
        r.value  = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/gclp_emitter.sv
// ----------------------------------------------------------------------------
// Gray coordinate result emitter
// Holds a snapshot of a finished line and sends one result per sensor through
// an output register, decoding each Gray field to binary on the way.
// ----------------------------------------------------------------------------
module gclp_emitter #(
  parameter int SENSORS    = gclp_pkg::SENSORS_DEF,
  parameter int COORD_BITS = gclp_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  gclp_pkg::snap_ctrl_t                    snap_ctrl_i,
  input  logic [SENSORS-1:0]                      present_i,
  input  logic [SENSORS-1:0]                      overflow_i,
  input  logic [SENSORS-1:0][COORD_BITS-1:0]      gray_i,
  output logic                                    busy_o,
  output logic                                    axis_is_y_o,
  output logic [gclp_pkg::SENSOR_IDX_W-1:0]       sensor_index_o,
  output logic [gclp_pkg::COORD_OUT_W-1:0]        coordinate_o,
  output logic                                    field_missing_o,
  output logic                                    overflowed_o,
  output logic                                    last_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i
);

  localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SENSORS - 1);
  localparam int WIDE_W = (COORD_BITS > gclp_pkg::COORD_OUT_W) ?
                          COORD_BITS : gclp_pkg::COORD_OUT_W;

  // Snapshot of the line being emitted.
  logic [SENSORS-1:0]                 present_q;
  logic [SENSORS-1:0]                 ovf_q;
  logic [SENSORS-1:0][COORD_BITS-1:0] gray_q;
  logic                               axis_y_q;

  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic             advance;

  logic [COORD_BITS-1:0] sel_gray;
  logic [COORD_BITS-1:0] sel_bin;
  logic [WIDE_W-1:0]     value_wide;
  logic                  sel_present;
  logic                  sel_ovf;

  // A result moves into the output register when that register is free.
  assign advance = busy_q && (!out_valid_q || out_ready_i);

  // Gray to binary: every binary bit is the XOR of all Gray bits at or above it.
  always_comb begin
    sel_gray    = gray_q[idx_q];
    sel_present = present_q[idx_q];
    sel_ovf     = ovf_q[idx_q];
    for (int b = 0; b < COORD_BITS; b++) begin
      sel_bin[b] = ^(sel_gray >> b);
    end
    if (!sel_present) begin
      value_wide = '0;
    end else if (sel_ovf) begin
      value_wide = WIDE_W'({COORD_BITS{1'b1}});
    end else begin
      value_wide = WIDE_W'(sel_bin);
    end
  end

  // Snapshot registers, loaded at the newline.
  always_ff @(posedge clk_i) begin
    if (snap_ctrl_i.load) begin
      present_q <= present_i;
      ovf_q     <= overflow_i;
      gray_q    <= gray_i;
      axis_y_q  <= snap_ctrl_i.axis_is_y;
    end
  end

  // Emission sequencing and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (snap_ctrl_i.load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (advance) begin
        if (idx_q == IDX_LAST) begin
          busy_q <= 1'b0;
          idx_q  <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      axis_is_y_o     <= axis_y_q;
      sensor_index_o  <= gclp_pkg::SENSOR_IDX_W'(idx_q);
      coordinate_o    <= value_wide[gclp_pkg::COORD_OUT_W-1:0];
      field_missing_o <= !sel_present;
      overflowed_o    <= sel_present && sel_ovf;
      last_o          <= (idx_q == IDX_LAST);
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/gray_coordinate_line_parser.sv
// ----------------------------------------------------------------------------
// Gray coordinate line parser
// Parses serial text lines of Gray coded hex fields into binary coordinates.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on rx_byte_i with in_valid_i / in_ready_o, one item per cycle
// while in_ready_o is high. A line starts with an axis letter, then a colon,
// then comma separated hex fields; a newline (0x0A) closes it.
// For a line with a known axis, the newline yields SENSORS result items on
// the out_* channel, one per cycle while the receiver does not stall; the first
// passes through the emitter's busy state and then its output register, and
// last_o marks the final one of the line.
// Parsing of the next line goes on while results drain; only a further
// newline is held off (in_ready_o low) until the previous line's results have
// all left the snapshot.
// When the receiver stalls, the output register holds its item and the
// snapshot waits; other bytes are still taken.
// Axis letters are set over the APB port (X at 0x0, Y at 0x4); the user must
// write them only while idle, which the block itself does not enforce. Reset
// clears the line state, the output valid and sets the letters to 'X' and 'Y'.
// ----------------------------------------------------------------------------
module gray_coordinate_line_parser #(
  parameter int SENSORS    = gclp_pkg::SENSORS_DEF,
  parameter int COORD_BITS = gclp_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gclp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gclp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gclp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // Input channel
  input  logic [gclp_pkg::BYTE_W-1:0]         rx_byte_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  // Result channel
  output logic                                axis_is_y_o,
  output logic [gclp_pkg::SENSOR_IDX_W-1:0]   sensor_index_o,
  output logic [gclp_pkg::COORD_OUT_W-1:0]    coordinate_o,
  output logic                                field_missing_o,
  output logic                                overflowed_o,
  output logic                                last_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i
);

  localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int FN_W  = $clog2(SENSORS + 1);
  localparam logic [FN_W-1:0] FN_MAX = FN_W'(SENSORS);

  // Configuration registers.
  logic [gclp_pkg::BYTE_W-1:0] x_letter_q;
  logic [gclp_pkg::BYTE_W-1:0] y_letter_q;
  gclp_pkg::cfg_reg_e          cfg_sel;
  logic                        cfg_we;

  // Line state.
  gclp_pkg::line_phase_e              phase_q, phase_d;
  gclp_pkg::line_axis_e               axis_q, axis_d;
  logic [FN_W-1:0]                    field_num_q, field_num_d;
  logic                               has_text_q, has_text_d;
  logic                               stopped_q, stopped_d;
  logic [SENSORS-1:0][COORD_BITS-1:0] gray_q, gray_d;
  logic [SENSORS-1:0]                 ovf_q, ovf_d;

  logic                  accept;
  logic                  is_nl;
  logic                  is_end;
  logic                  field_open;
  logic                  field_close;
  logic                  stop_eff;
  logic [IDX_W-1:0]      cur_idx;
  logic [COORD_BITS-1:0] cur_gray;
  gclp_pkg::hex_digit_t  hex;

  logic                  busy;
  logic                  count_inc;
  logic [FN_W-1:0]       count;
  logic [SENSORS-1:0]    present;
  gclp_pkg::snap_ctrl_t  snap_ctrl;

  // APB register access; writes complete in the access phase.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = gclp_pkg::cfg_reg_e'(paddr[gclp_pkg::APB_ADDR_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_letter_q <= gclp_pkg::X_LETTER_RST;
      y_letter_q <= gclp_pkg::Y_LETTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        gclp_pkg::REG_X_LETTER: x_letter_q <= pwdata[gclp_pkg::BYTE_W-1:0];
        gclp_pkg::REG_Y_LETTER: y_letter_q <= pwdata[gclp_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      gclp_pkg::REG_X_LETTER: prdata = gclp_pkg::APB_DATA_W'(x_letter_q);
      gclp_pkg::REG_Y_LETTER: prdata = gclp_pkg::APB_DATA_W'(y_letter_q);
      default:                prdata = '0;
    endcase
  end

  // Input handshake: only a newline waits for the emitter to drain.
  assign is_nl      = (rx_byte_i == gclp_pkg::CHAR_NEWLINE);
  assign in_ready_o = !busy || !is_nl;
  assign accept     = in_valid_i && in_ready_o;
  assign is_end     = (rx_byte_i == gclp_pkg::CHAR_NUL) ||
                      (rx_byte_i == gclp_pkg::CHAR_COLON);
  assign hex        = gclp_pkg::hex_decode(rx_byte_i);

  // Current field slot.
  assign field_open  = (field_num_q < FN_MAX);
  assign field_close = has_text_q && field_open;
  assign cur_idx     = field_num_q[IDX_W-1:0];
  assign cur_gray    = gray_q[cur_idx];
  assign stop_eff    = has_text_q && stopped_q;

  // Line phase and axis: next state.
  always_comb begin
    phase_d = phase_q;
    axis_d  = axis_q;
    if (accept) begin
      if (is_nl) begin
        phase_d = gclp_pkg::PH_START;
        axis_d  = gclp_pkg::AX_NONE;
      end else begin
        unique case (phase_q)
          gclp_pkg::PH_START: begin
            if (rx_byte_i == x_letter_q && rx_byte_i != gclp_pkg::CHAR_NUL) begin
              axis_d = gclp_pkg::AX_X;
            end else if (rx_byte_i == y_letter_q &&
                         rx_byte_i != gclp_pkg::CHAR_NUL) begin
              axis_d = gclp_pkg::AX_Y;
            end else begin
              axis_d = gclp_pkg::AX_NONE;
            end
            phase_d = (axis_d == gclp_pkg::AX_NONE) ? gclp_pkg::PH_DONE
                                                    : gclp_pkg::PH_AXIS;
          end
          gclp_pkg::PH_AXIS: begin
            if (rx_byte_i == gclp_pkg::CHAR_NUL) begin
              phase_d = gclp_pkg::PH_DONE;
            end else if (rx_byte_i == gclp_pkg::CHAR_COLON) begin
              phase_d = gclp_pkg::PH_FIELDS;
            end
          end
          gclp_pkg::PH_FIELDS: begin
            if (is_end) begin
              phase_d = gclp_pkg::PH_DONE;
            end
          end
          gclp_pkg::PH_DONE: ;
          default: ;
        endcase
      end
    end
  end

  // Field gathering: hex digits shift into the current slot.
  always_comb begin
    field_num_d = field_num_q;
    has_text_d  = has_text_q;
    stopped_d   = stopped_q;
    gray_d      = gray_q;
    ovf_d       = ovf_q;
    if (accept) begin
      if (is_nl) begin
        field_num_d = '0;
        has_text_d  = 1'b0;
        stopped_d   = 1'b0;
        gray_d      = '0;
        ovf_d       = '0;
      end else if (phase_q == gclp_pkg::PH_FIELDS) begin
        if (is_end || rx_byte_i == gclp_pkg::CHAR_COMMA) begin
          if (field_close) begin
            field_num_d = field_num_q + 1'b1;
          end
          has_text_d = 1'b0;
          if (rx_byte_i == gclp_pkg::CHAR_COMMA) begin
            stopped_d = 1'b0;
          end
        end else begin
          has_text_d = 1'b1;
          stopped_d  = stop_eff;
          if (field_open && !stop_eff) begin
            if (!hex.is_hex) begin
              stopped_d = 1'b1;
            end else if (!ovf_q[cur_idx]) begin
              if (cur_gray[COORD_BITS-1 -: 4] != '0) begin
                gray_d[cur_idx] = '1;
                ovf_d[cur_idx]  = 1'b1;
              end else begin
                gray_d[cur_idx] = (cur_gray << 4) | COORD_BITS'(hex.value);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gclp_pkg::PH_START;
      axis_q      <= gclp_pkg::AX_NONE;
      field_num_q <= '0;
      has_text_q  <= 1'b0;
      stopped_q   <= 1'b0;
      gray_q      <= '0;
      ovf_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      axis_q      <= axis_d;
      field_num_q <= field_num_d;
      has_text_q  <= has_text_d;
      stopped_q   <= stopped_d;
      gray_q      <= gray_d;
      ovf_q       <= ovf_d;
    end
  end

  // At the newline, count the fields that arrived, including an open one.
  assign count_inc = (phase_q == gclp_pkg::PH_FIELDS || phase_q == gclp_pkg::PH_DONE) &&
                     field_close;
  assign count     = field_num_q + FN_W'(count_inc);

  always_comb begin
    for (int i = 0; i < SENSORS; i++) begin
      present[i] = (count > FN_W'(i));
    end
  end

  assign snap_ctrl.load      = accept && is_nl && (phase_q != gclp_pkg::PH_START) &&
                               (axis_q != gclp_pkg::AX_NONE);
  assign snap_ctrl.axis_is_y = (axis_q == gclp_pkg::AX_Y);

  // Result emission.
  gclp_emitter #(
    .SENSORS   (SENSORS),
    .COORD_BITS(COORD_BITS)
  ) u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_ctrl_i    (snap_ctrl),
    .present_i      (present),
    .overflow_i     (ovf_q),
    .gray_i         (gray_q),
    .busy_o         (busy),
    .axis_is_y_o    (axis_is_y_o),
    .sensor_index_o (sensor_index_o),
    .coordinate_o   (coordinate_o),
    .field_missing_o(field_missing_o),
    .overflowed_o   (overflowed_o),
    .last_o         (last_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule
